FILE: src/vnta_pkg.sv
// Shared types, constants and helper functions of the vertex normal and tangent accumulator.
`timescale 1ns / 1ps

package vnta_pkg;

  localparam int MAX_VERTICES_DEF = 4096;

  localparam int IDXW  = 12;   // vertex index field
  localparam int CRDW  = 32;   // Q16.16 coordinate
  localparam int UNITW = 18;   // Q1.16 unit component
  localparam int CNTW  = 16;   // face count
  localparam int SUMW  = 36;   // accumulated sum component
  localparam int MAGW  = 62;   // magnitude fed to the normaliser
  localparam int PRODW = 62;   // product and cross product width
  localparam int OPW   = 31;   // reduced multiplier operand
  localparam int EMW   = 33;   // edge or uv difference magnitude

  localparam int S_TDATA_W = 208;
  localparam int M_TDATA_W = 128;

  typedef enum logic [2:0] {
    CMD_WR_POS  = 3'd0,
    CMD_WR_TEX  = 3'd1,
    CMD_ADD_TRI = 3'd2,
    CMD_READ    = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_t;

  typedef struct packed {
    logic                  start;
    logic [2:0][MAGW-1:0]  mag;
    logic [2:0]            neg;
  } norm_req_t;

  typedef struct packed {
    logic                  done;
    logic [2:0][UNITW-1:0] unit;
  } norm_rsp_t;

  // Saturating add of a unit component to a sum component.
  function automatic logic [SUMW-1:0] sat_add(input logic signed [SUMW-1:0] a,
                                              input logic signed [UNITW-1:0] b);
    logic signed [SUMW:0] s;
    s = (SUMW+1)'(a) + (SUMW+1)'(b);
    if (s[SUMW] != s[SUMW-1]) begin
      return s[SUMW] ? {1'b1, {(SUMW-1){1'b0}}} : {1'b0, {(SUMW-1){1'b1}}};
    end
    return s[SUMW-1:0];
  endfunction

  // Sign and magnitude of c - a.
  function automatic logic [EMW:0] abs_diff(input logic signed [CRDW-1:0] c,
                                            input logic signed [CRDW-1:0] a);
    logic signed [EMW-1:0] d;
    d = EMW'(c) - EMW'(a);
    return {d[EMW-1], d[EMW-1] ? EMW'(-d) : EMW'(d)};
  endfunction

  // Signed multiplier operand from a reduced magnitude below 2^30.
  function automatic logic signed [OPW-1:0] op_of(input logic [EMW-1:0] m, input logic neg);
    logic signed [OPW-1:0] v;
    v = {1'b0, m[29:0]};
    return neg ? -v : v;
  endfunction

  function automatic logic [MAGW-1:0] mag_of(input logic signed [MAGW-1:0] v);
    return v[MAGW-1] ? MAGW'(-v) : MAGW'(v);
  endfunction

endpackage

FILE: src/vnta_norm.sv
// Shared normaliser: bit-serial scaling, square sum, integer root and three divisions.
`timescale 1ns / 1ps

module vnta_norm import vnta_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  norm_req_t req,
  output norm_rsp_t rsp
);

  typedef enum logic [5:0] {
    NS_IDLE  = 6'b000001,
    NS_SHIFT = 6'b000010,
    NS_SQ    = 6'b000100,
    NS_ROOT  = 6'b001000,
    NS_NUM   = 6'b010000,
    NS_DIV   = 6'b100000
  } nstate_t;

  nstate_t               state;
  logic [2:0][MAGW-1:0]  m;
  logic [2:0]            neg;
  logic [1:0]            sq_cnt;
  logic [59:0]           sq;
  logic [29:0]           sq_op;
  logic [MAGW-1:0]       acc;
  logic [MAGW-1:0]       root;
  logic [MAGW-1:0]       rbit;
  logic [MAGW:0]         root_try;
  logic [1:0]            ci;
  logic [4:0]            dcnt;
  logic [31:0]           drem;
  logic [16:0]           nlo;
  logic [16:0]           quo;
  logic [16:0]           quo_next;
  logic [46:0]           num;
  logic [32:0]           div_try;
  logic                  div_ge;
  logic [2:0][UNITW-1:0] unit;
  logic                  done;
  logic                  any_hi;
  logic                  any_top;
  logic                  all_zero;

  always_comb begin
    any_hi   = 1'b0;
    any_top  = 1'b0;
    all_zero = 1'b1;
    for (int k = 0; k < 3; k++) begin
      any_hi   = any_hi | (|m[k][MAGW-1:30]);
      any_top  = any_top | (|m[k][MAGW-1:29]);
      all_zero = all_zero & (req.mag[k] == '0);
    end
    case (sq_cnt)
      2'd0:    sq_op = m[0][29:0];
      2'd1:    sq_op = m[1][29:0];
      2'd2:    sq_op = m[2][29:0];
      default: sq_op = '0;
    endcase
    root_try = {1'b0, root} + {1'b0, rbit};
    num      = 47'({m[ci][29:0], 16'd0}) + 47'(root[31:1]);
    div_try  = {drem, nlo[16]};
    div_ge   = div_try >= {1'b0, root[31:0]};
    quo_next = {quo[15:0], div_ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= NS_IDLE;
      done  <= 1'b0;
    end else begin
      // The response pulses for one cycle, for a zero vector or after the last division.
      done <= (state == NS_IDLE && req.start && all_zero) ||
              (state == NS_DIV && dcnt == 5'd16 && ci == 2'd2);
      case (state)
        NS_IDLE: begin
          if (req.start) begin
            m   <= req.mag;
            neg <= req.neg;
            if (all_zero) begin
              unit <= '0;
            end else begin
              state <= NS_SHIFT;
            end
          end
        end
        NS_SHIFT: begin
          // One bit a cycle until the largest magnitude sits in [2^29, 2^30).
          if (any_hi) begin
            for (int k = 0; k < 3; k++) m[k] <= m[k] >> 1;
          end else if (!any_top) begin
            for (int k = 0; k < 3; k++) m[k] <= m[k] << 1;
          end else begin
            state  <= NS_SQ;
            sq_cnt <= '0;
            acc    <= '0;
          end
        end
        NS_SQ: begin
          sq_cnt <= sq_cnt + 2'd1;
          sq     <= sq_op * sq_op;
          if (sq_cnt != 2'd0) acc <= acc + MAGW'(sq);
          if (sq_cnt == 2'd3) begin
            state <= NS_ROOT;
            root  <= '0;
            rbit  <= MAGW'(1) << 60;
          end
        end
        NS_ROOT: begin
          if ({1'b0, acc} >= root_try) begin
            acc  <= acc - root_try[MAGW-1:0];
            root <= (root >> 1) + rbit;
          end else begin
            root <= root >> 1;
          end
          rbit <= rbit >> 2;
          if (rbit[0]) begin
            state <= NS_NUM;
            ci    <= '0;
          end
        end
        NS_NUM: begin
          // The upper quotient bits are known to be zero, so start part way in.
          drem  <= 32'(num[46:17]);
          nlo   <= num[16:0];
          quo   <= '0;
          dcnt  <= '0;
          state <= NS_DIV;
        end
        NS_DIV: begin
          drem <= div_ge ? 32'(div_try - {1'b0, root[31:0]}) : div_try[31:0];
          nlo  <= {nlo[15:0], 1'b0};
          quo  <= quo_next;
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd16) begin
            unit[ci] <= neg[ci] ? -UNITW'({1'b0, quo_next}) : UNITW'({1'b0, quo_next});
            if (ci == 2'd2) begin
              state <= NS_IDLE;
            end else begin
              ci    <= ci + 2'd1;
              state <= NS_NUM;
            end
          end
        end
        default: state <= NS_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.unit = unit;

endmodule

FILE: src/vertex_normal_tangent_accumulator.sv
// Top level of the vertex normal and tangent accumulator: stores, sequencer and output register.
`timescale 1ns / 1ps

// The block keeps per-vertex positions, texture coordinates, normal and tangent sums and face
// counts in on-chip memories of MAX_VERTICES rows. Requests arrive on the s_ stream with the
// command in s_tuser; only a read request produces a result on the m_ stream. A position or
// texture coordinate write is stored on acceptance and the block is ready again at once. An
// add-triangle request fetches the three corners, reduces the edges, forms the cross product,
// the uv determinant and the tangent on one shared multiplier, and then uses the one shared
// normaliser for the face normal and, when texture coordinates are on and the uv triangle is
// not degenerate, the tangent. A normalisation runs a one-bit-per-cycle scaling loop, a square
// sum, a 31-step square root and three divisions. The sums of the three corners are then
// updated by read-modify-write, one corner after another. A read request fetches the vertex row
// and runs two normalisations, or none when the vertex has no faces. After reset, and after a
// clear request, the sums and counts are swept to zero one row a cycle, and no request is taken
// during the sweep. s_tready is low whenever a request is in progress; a finished result waits
// in the output register, and the block takes the next request while it waits, holding only if
// a second result becomes due.
module vertex_normal_tangent_accumulator import vnta_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,   // texcoords_enabled
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // vertex_index, pos_x, pos_y, pos_z, tex_s, tex_t, corner_a, corner_b, corner_c
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [2:0]           s_tuser,     // command
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // normal_x, normal_y, normal_z, tangent_x, tangent_y, tangent_z, shared_count, zero padding
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int AW   = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
  localparam int CLRW = AW + 1;

  typedef enum logic [12:0] {
    S_CLEAR   = 13'b0000000000001,
    S_IDLE    = 13'b0000000000010,
    S_TRI_RD  = 13'b0000000000100,
    S_TRI_RED = 13'b0000000001000,
    S_TRI_MUL = 13'b0000000010000,
    S_TRI_NN  = 13'b0000000100000,
    S_TRI_NT  = 13'b0000001000000,
    S_UPD_RD  = 13'b0000010000000,
    S_UPD_WR  = 13'b0000100000000,
    S_RD_FET  = 13'b0001000000000,
    S_RD_NN   = 13'b0010000000000,
    S_RD_NT   = 13'b0100000000000,
    S_OUT     = 13'b1000000000000
  } state_t;

  // Request fields.
  cmd_t            in_cmd;
  logic [IDXW-1:0] in_vi;
  logic [IDXW-1:0] in_ca;
  logic [IDXW-1:0] in_cb;
  logic [IDXW-1:0] in_cc;

  assign in_cmd = cmd_t'(s_tuser);
  assign in_vi  = s_tdata[11:0];
  assign in_ca  = s_tdata[183:172];
  assign in_cb  = s_tdata[195:184];
  assign in_cc  = s_tdata[207:196];

  function automatic logic in_range(input logic [IDXW-1:0] idx);
    return 17'(idx) < 17'(MAX_VERTICES);
  endfunction

  // Stores: one row per vertex.
  logic [3*CRDW-1:0] pos_mem  [MAX_VERTICES];
  logic [2*CRDW-1:0] tex_mem  [MAX_VERTICES];
  logic [3*SUMW-1:0] nsum_mem [MAX_VERTICES];
  logic [3*SUMW-1:0] tsum_mem [MAX_VERTICES];
  logic [CNTW-1:0]   cnt_mem  [MAX_VERTICES];

  logic [3*CRDW-1:0] pos_rd;
  logic [2*CRDW-1:0] tex_rd;
  logic [3*SUMW-1:0] nsum_rd;
  logic [3*SUMW-1:0] tsum_rd;
  logic [CNTW-1:0]   cnt_rd;

  state_t            state;
  logic              tex_en;
  logic [CLRW-1:0]   clr;
  logic [AW-1:0]     a_vi;
  logic [AW-1:0]     a_ca;
  logic [AW-1:0]     a_cb;
  logic [AW-1:0]     a_cc;
  logic              vi_ok;
  logic [1:0]        ctr;
  logic [AW-1:0]     corner;
  logic [AW-1:0]     ra;
  logic [AW-1:0]     sum_wa;
  logic              accept;
  logic              pos_we;
  logic              tex_we;
  logic              sum_we;
  logic [3*SUMW-1:0] nsum_wdata;
  logic [3*SUMW-1:0] tsum_wdata;
  logic [CNTW-1:0]   cnt_wdata;

  // Triangle datapath.
  logic [3*CRDW-1:0]       pa;
  logic [3*CRDW-1:0]       pb;
  logic [2*CRDW-1:0]       ta;
  logic [2*CRDW-1:0]       tb;
  logic [5:0][EMW-1:0]     emag;
  logic [5:0]              eneg;
  logic [3:0][EMW-1:0]     smag;
  logic [3:0]              sneg;
  logic                    any_e;
  logic                    any_s;
  logic [3:0]              mi;
  logic signed [OPW-1:0]   opa;
  logic signed [OPW-1:0]   opb;
  logic signed [PRODW-1:0] prod_q;
  logic signed [PRODW-1:0] acc_q;
  logic signed [PRODW-1:0] res [7];
  logic                    det_neg;
  logic [2:0][UNITW-1:0]   nu;
  logic [2:0][UNITW-1:0]   tu;
  logic [CNTW-1:0]         out_cnt;

  norm_req_t req;
  norm_rsp_t rsp;
  logic      nbusy;

  vnta_norm u_norm (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign det_neg  = res[3][PRODW-1];

  // Address selection for the memories.
  always_comb begin
    case (ctr)
      2'd0:    corner = a_ca;
      2'd1:    corner = a_cb;
      default: corner = a_cc;
    endcase
    ra     = (state == S_TRI_RD || state == S_UPD_RD) ? corner : a_vi;
    sum_wa = (state == S_CLEAR) ? clr[AW-1:0] : corner;
    pos_we = accept && in_cmd == CMD_WR_POS && in_range(in_vi);
    tex_we = accept && in_cmd == CMD_WR_TEX && in_range(in_vi);
    sum_we = (state == S_CLEAR) || (state == S_UPD_WR);
  end

  // Read-modify-write data for a corner; all zero during the clearing sweep.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nsum_wdata[SUMW*i +: SUMW] = sat_add($signed(nsum_rd[SUMW*i +: SUMW]), $signed(nu[i]));
      tsum_wdata[SUMW*i +: SUMW] = sat_add($signed(tsum_rd[SUMW*i +: SUMW]), $signed(tu[i]));
    end
    cnt_wdata = (cnt_rd == {CNTW{1'b1}}) ? cnt_rd : cnt_rd + CNTW'(1);
    if (state == S_CLEAR) begin
      nsum_wdata = '0;
      tsum_wdata = '0;
      cnt_wdata  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[AW'(in_vi)] <= s_tdata[107:12];
    pos_rd <= pos_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (tex_we) tex_mem[AW'(in_vi)] <= s_tdata[171:108];
    tex_rd <= tex_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      nsum_mem[sum_wa] <= nsum_wdata;
      tsum_mem[sum_wa] <= tsum_wdata;
      cnt_mem[sum_wa]  <= cnt_wdata;
    end
    nsum_rd <= nsum_mem[ra];
    tsum_rd <= tsum_mem[ra];
    cnt_rd  <= cnt_mem[ra];
  end

  // Edge and uv reduction test: any magnitude still at or above 2^30.
  always_comb begin
    any_e = 1'b0;
    any_s = 1'b0;
    for (int k = 0; k < 6; k++) any_e = any_e | (|emag[k][EMW-1:30]);
    for (int k = 0; k < 4; k++) any_s = any_s | (|smag[k][EMW-1:30]);
  end

  // Shared multiplier operands: pairs give (b-a) x (c-a), the uv determinant and the tangent.
  always_comb begin
    case (mi)
      4'd0:    begin opa = op_of(emag[4], eneg[4]); opb = op_of(emag[2], eneg[2]); end
      4'd1:    begin opa = op_of(emag[5], eneg[5]); opb = op_of(emag[1], eneg[1]); end
      4'd2:    begin opa = op_of(emag[5], eneg[5]); opb = op_of(emag[0], eneg[0]); end
      4'd3:    begin opa = op_of(emag[3], eneg[3]); opb = op_of(emag[2], eneg[2]); end
      4'd4:    begin opa = op_of(emag[3], eneg[3]); opb = op_of(emag[1], eneg[1]); end
      4'd5:    begin opa = op_of(emag[4], eneg[4]); opb = op_of(emag[0], eneg[0]); end
      4'd6:    begin opa = op_of(smag[0], sneg[0]); opb = op_of(smag[3], sneg[3]); end
      4'd7:    begin opa = op_of(smag[2], sneg[2]); opb = op_of(smag[1], sneg[1]); end
      4'd8:    begin opa = op_of(emag[0], eneg[0]); opb = op_of(smag[3], sneg[3]); end
      4'd9:    begin opa = op_of(emag[3], eneg[3]); opb = op_of(smag[1], sneg[1]); end
      4'd10:   begin opa = op_of(emag[1], eneg[1]); opb = op_of(smag[3], sneg[3]); end
      4'd11:   begin opa = op_of(emag[4], eneg[4]); opb = op_of(smag[1], sneg[1]); end
      4'd12:   begin opa = op_of(emag[2], eneg[2]); opb = op_of(smag[3], sneg[3]); end
      4'd13:   begin opa = op_of(emag[5], eneg[5]); opb = op_of(smag[1], sneg[1]); end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  // Normaliser request: the source vector follows the state.
  always_comb begin
    req.start = 1'b0;
    req.mag   = '0;
    req.neg   = '0;
    case (state)
      S_TRI_NN: begin
        for (int i = 0; i < 3; i++) begin
          req.mag[i] = mag_of(res[i]);
          req.neg[i] = res[i][PRODW-1];
        end
        req.start = !nbusy;
      end
      S_TRI_NT: begin
        // The tangent takes the sign of the uv determinant.
        for (int i = 0; i < 3; i++) begin
          req.mag[i] = mag_of(res[4+i]);
          req.neg[i] = res[4+i][PRODW-1] ^ det_neg;
        end
        req.start = !nbusy;
      end
      S_RD_NN: begin
        for (int i = 0; i < 3; i++) begin
          req.mag[i] = mag_of(MAGW'($signed(nsum_rd[SUMW*i +: SUMW])));
          req.neg[i] = nsum_rd[SUMW*i+SUMW-1];
        end
        req.start = !nbusy;
      end
      S_RD_NT: begin
        for (int i = 0; i < 3; i++) begin
          req.mag[i] = mag_of(MAGW'($signed(tsum_rd[SUMW*i +: SUMW])));
          req.neg[i] = tsum_rd[SUMW*i+SUMW-1];
        end
        req.start = !nbusy;
      end
      default: req.start = 1'b0;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      nbusy    <= 1'b0;
      m_tvalid <= 1'b0;
      tex_en   <= 1'b0;
    end else begin
      if (cfg_we) tex_en <= cfg_wdata;
      // The output register is loaded from S_OUT once it is empty or being taken.
      if (state == S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (req.start) begin
        nbusy <= 1'b1;
      end else if (rsp.done) begin
        nbusy <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + CLRW'(1);
          if (clr == CLRW'(MAX_VERTICES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid) begin
            a_vi  <= AW'(in_vi);
            a_ca  <= AW'(in_ca);
            a_cb  <= AW'(in_cb);
            a_cc  <= AW'(in_cc);
            vi_ok <= in_range(in_vi);
            ctr   <= '0;
            case (in_cmd)
              CMD_ADD_TRI: begin
                // A triangle with any corner outside the stores is dropped.
                if (in_range(in_ca) && in_range(in_cb) && in_range(in_cc)) state <= S_TRI_RD;
              end
              CMD_READ:  state <= S_RD_FET;
              CMD_CLEAR: begin
                clr   <= '0;
                state <= S_CLEAR;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_TRI_RD: begin
          ctr <= ctr + 2'd1;
          case (ctr)
            2'd1: begin
              pa <= pos_rd;
              ta <= tex_rd;
            end
            2'd2: begin
              pb <= pos_rd;
              tb <= tex_rd;
            end
            2'd3: begin
              for (int i = 0; i < 3; i++) begin
                {eneg[i], emag[i]}     <= abs_diff(pos_rd[CRDW*i +: CRDW], pa[CRDW*i +: CRDW]);
                {eneg[3+i], emag[3+i]} <= abs_diff(pb[CRDW*i +: CRDW], pa[CRDW*i +: CRDW]);
              end
              for (int i = 0; i < 2; i++) begin
                {sneg[i], smag[i]}     <= abs_diff(tex_rd[CRDW*i +: CRDW], ta[CRDW*i +: CRDW]);
                {sneg[2+i], smag[2+i]} <= abs_diff(tb[CRDW*i +: CRDW], ta[CRDW*i +: CRDW]);
              end
              state <= S_TRI_RED;
            end
            default: ;
          endcase
        end
        S_TRI_RED: begin
          // Edges and uv differences are each scaled down together, a bit a cycle. The uv
          // differences only count when texture coordinates are on.
          if (any_e) begin
            for (int k = 0; k < 6; k++) emag[k] <= emag[k] >> 1;
          end
          if (tex_en && any_s) begin
            for (int k = 0; k < 4; k++) smag[k] <= smag[k] >> 1;
          end
          if (!any_e && !(tex_en && any_s)) begin
            mi    <= '0;
            state <= S_TRI_MUL;
          end
        end
        S_TRI_MUL: begin
          // Product of pair mi is registered; the previous product is folded in.
          mi     <= mi + 4'd1;
          prod_q <= opa * opb;
          if (mi != 4'd0) begin
            if (mi[0]) begin
              acc_q <= prod_q;
            end else begin
              res[3'((mi >> 1) - 4'd1)] <= acc_q - prod_q;
            end
          end
          if (mi == 4'd14) state <= S_TRI_NN;
        end
        S_TRI_NN: begin
          if (rsp.done) begin
            nu <= rsp.unit;
            if (tex_en && res[3] != '0) begin
              state <= S_TRI_NT;
            end else begin
              tu    <= '0;
              ctr   <= '0;
              state <= S_UPD_RD;
            end
          end
        end
        S_TRI_NT: begin
          if (rsp.done) begin
            tu    <= rsp.unit;
            ctr   <= '0;
            state <= S_UPD_RD;
          end
        end
        S_UPD_RD: state <= S_UPD_WR;
        S_UPD_WR: begin
          // Corners go strictly one after another, so a repeated corner sees its own update.
          ctr <= ctr + 2'd1;
          if (ctr == 2'd2) begin
            state <= S_IDLE;
          end else begin
            state <= S_UPD_RD;
          end
        end
        S_RD_FET: begin
          ctr <= ctr + 2'd1;
          if (ctr == 2'd1) begin
            if (!vi_ok || cnt_rd == '0) begin
              nu      <= '0;
              tu      <= '0;
              out_cnt <= '0;
              state   <= S_OUT;
            end else begin
              out_cnt <= cnt_rd;
              state   <= S_RD_NN;
            end
          end
        end
        S_RD_NN: begin
          if (rsp.done) begin
            nu    <= rsp.unit;
            state <= S_RD_NT;
          end
        end
        S_RD_NT: begin
          if (rsp.done) begin
            tu    <= rsp.unit;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {4'd0, out_cnt, tu, nu};
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/vnta_checker.sv
// Port-level checker of the accumulator, bound to the top level.
`timescale 1ns / 1ps

module vnta_checker import vnta_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [2:0]           s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  // A read request keeps the block busy at least for the next cycle.
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == CMD_READ |=> !s_tready)
    else $error("block ready right after a read request");

  // A result that is not taken stays as it is.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A vertex without faces reports zero vectors.
  a_zero_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[123:108] == '0 |-> m_tdata[107:0] == '0)
    else $error("non-zero vectors for a vertex without faces");

  // The x components of the normal and tangent stay within one, and the padding is zero.
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[127:124] == '0
      && $signed(m_tdata[17:0]) <= 18'sd65536 && $signed(m_tdata[17:0]) >= -18'sd65536
      && $signed(m_tdata[71:54]) <= 18'sd65536 && $signed(m_tdata[71:54]) >= -18'sd65536)
    else $error("unit component out of range");

endmodule

bind vertex_normal_tangent_accumulator vnta_checker u_vnta_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
